FILE: hdl/tga_rle_rgb565_decoder_macros.svh
// assertion macros shared by the decoder rtl
`ifndef TGA_RLE_RGB565_DECODER_MACROS_SVH
`define TGA_RLE_RGB565_DECODER_MACROS_SVH

// property checked at every clock edge outside reset
`define TRLE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define TRLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/trle_pkg.sv
// types and constants of the targa run-length decoder
package trle_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ColorW   = 16;
  localparam int unsigned RunW     = 8;
  localparam int unsigned PixCntW  = 24;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] CfgIdxRleMode     = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxTotalPixels = 1'd1;

  localparam logic                RleModeReset     = 1'b1;
  localparam logic [PixCntW-1:0]  TotalPixelsReset = '0;

  typedef struct packed {
    logic [ColorW-1:0]  pixel_565;
    logic [RunW-1:0]    run_length;
    logic [PixCntW-1:0] start_index;
    logic               image_done;
    logic               overrun;
  } trle_pix_t;

endpackage

FILE: hdl/trle_ifs.sv
// handshake channels of the decoder: byte input, run output, register writes
interface trle_byte_if import trle_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface trle_pix_if import trle_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ColorW-1:0]  pixel_565;
  logic [RunW-1:0]    run_length;
  logic [PixCntW-1:0] start_index;
  logic               image_done;
  logic               overrun;

  modport source (output valid, output pixel_565, output run_length, output start_index,
                  output image_done, output overrun, input ready);
  modport sink (input valid, input pixel_565, input run_length, input start_index,
                input image_done, input overrun, output ready);
endinterface

interface trle_cfg_if import trle_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/tga_rle_rgb565_decoder.sv
// Targa 24-bit run-length pixel decoder with RGB565 run output.
// byte_i carries the pixel-data bytes after the header, one per transfer.
// pix_o gives one transfer per finished pixel or run: color, length,
// first pixel index, end-of-image and overrun flags.
// cfg_i writes register 0 (run-length mode) and register 1 (pixel total);
// write only while no byte is in flight and pix_o holds nothing.
// a transferred byte enters the input register and is decoded into the
// output register, which drives pix_o, once that register is free or taken.
// throughput: one byte per cycle while pix_o is not stalled;
// a triple of three bytes (four with a packet byte) gives one run.
// when pix_o is stalled the pipeline holds and byte_i.ready drops once the
// input register is full; bytes that give no run still wait for the stall.
// reset clears the decode state, selects run-length mode and sets the pixel
// total to zero, so bytes are dropped until a total is written.
// bytes after the last pixel are taken and dropped.
`include "tga_rle_rgb565_decoder_macros.svh"

module tga_rle_rgb565_decoder import trle_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  trle_byte_if.sink    byte_i,
  trle_pix_if.source   pix_o,
  trle_cfg_if.sink     cfg_i
);

  logic               rle_mode_q;
  logic [PixCntW-1:0] total_pixels_q;
  logic               in_valid_q;
  logic [ByteW-1:0]   in_byte_q;
  logic               out_valid_q, out_valid_d;
  trle_pix_t          out_q;
  logic               advance;
  logic               res_valid;
  trle_pix_t          res;

  assign advance = in_valid_q && (!out_valid_q || pix_o.ready);
  assign byte_i.ready = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rle_mode_q <= RleModeReset;
      total_pixels_q <= TotalPixelsReset;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CfgIdxRleMode) begin
        rle_mode_q <= cfg_i.data[0];
      end
      if (cfg_i.index == CfgIdxTotalPixels) begin
        total_pixels_q <= cfg_i.data[PixCntW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.data_byte;
    end
  end

  trle_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .data_byte_i    (in_byte_q),
    .rle_mode_i     (rle_mode_q),
    .total_pixels_i (total_pixels_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res_valid;
    end else if (pix_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign pix_o.valid       = out_valid_q;
  assign pix_o.pixel_565   = out_q.pixel_565;
  assign pix_o.run_length  = out_q.run_length;
  assign pix_o.start_index = out_q.start_index;
  assign pix_o.image_done  = out_q.image_done;
  assign pix_o.overrun     = out_q.overrun;

  `TRLE_ASSERT(a_empty_input_ready, clk_i, rst_ni,
    !in_valid_q |-> byte_i.ready, "input register empty but not ready")
  `TRLE_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni,
    advance && res_valid, out_valid_q, "decoded run lost")
  `TRLE_ASSERT_NEXT(a_stall_holds_byte, clk_i, rst_ni,
    in_valid_q && !advance, in_valid_q && $stable(in_byte_q), "held byte dropped")

endmodule

FILE: hdl/trle_core.sv
// packet parser and run builder: decode state and one byte step
`include "tga_rle_rgb565_decoder_macros.svh"

module trle_core import trle_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [ByteW-1:0]   data_byte_i,
  input  logic               rle_mode_i,
  input  logic [PixCntW-1:0] total_pixels_i,
  output logic               res_valid_o,
  output trle_pix_t          res_o
);

  localparam logic [1:0] PhPacket = 2'd0;
  localparam logic [1:0] PhBlue   = 2'd1;
  localparam logic [1:0] PhGreen  = 2'd2;
  localparam logic [1:0] PhRed    = 2'd3;

  logic [1:0]         phase_q, phase_d;
  logic               repeat_q, repeat_d;
  logic [RunW-1:0]    left_q, left_d;
  logic [ByteW-1:0]   blue_q, blue_d;
  logic [ByteW-1:0]   green_q, green_d;
  logic [PixCntW-1:0] done_q, done_d;
  logic               finished_q, finished_d;

  logic               active;
  logic [PixCntW-1:0] remaining;
  logic [RunW-1:0]    left_eff, left_next, run;
  logic               over, fin;
  logic [ColorW-1:0]  color;

  assign active    = !finished_q && (done_q < total_pixels_i);
  assign remaining = total_pixels_i - done_q;
  assign left_eff  = (left_q == '0) ? RunW'(1) : left_q;
  assign left_next = left_eff - RunW'(1);
  assign color     = {data_byte_i[7:3], green_q[7:2], blue_q[7:3]};

  always_comb begin
    run = RunW'(1);
    over = 1'b0;
    if (rle_mode_i && repeat_q) begin
      if (PixCntW'(left_eff) > remaining) begin
        run = remaining[RunW-1:0];
        over = 1'b1;
      end else begin
        run = left_eff;
      end
    end else if (rle_mode_i) begin
      over = (remaining == PixCntW'(1)) && (left_next != '0);
    end
  end

  assign fin = (PixCntW'(run) == remaining);

  always_comb begin
    phase_d = phase_q;
    repeat_d = repeat_q;
    left_d = left_q;
    blue_d = blue_q;
    green_d = green_q;
    done_d = done_q;
    finished_d = finished_q;
    res_valid_o = 1'b0;
    res_o = '{pixel_565: color, run_length: run, start_index: done_q,
              image_done: fin, overrun: over};
    if (step_i && active) begin
      case (phase_q)
        PhPacket: begin
          if (rle_mode_i) begin
            repeat_d = data_byte_i[7];
            left_d = {1'b0, data_byte_i[6:0]} + RunW'(1);
            phase_d = PhBlue;
          end else begin
            blue_d = data_byte_i;
            phase_d = PhGreen;
          end
        end
        PhBlue: begin
          blue_d = data_byte_i;
          phase_d = PhGreen;
        end
        PhGreen: begin
          green_d = data_byte_i;
          phase_d = PhRed;
        end
        default: begin
          if (!rle_mode_i) begin
            phase_d = PhPacket;
          end else if (repeat_q) begin
            left_d = '0;
            phase_d = PhPacket;
          end else begin
            left_d = left_next;
            phase_d = (left_next != '0) ? PhBlue : PhPacket;
          end
          done_d = done_q + PixCntW'(run);
          finished_d = fin;
          res_valid_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhPacket;
      repeat_q <= 1'b0;
      left_q <= '0;
      blue_q <= '0;
      green_q <= '0;
      done_q <= '0;
      finished_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      repeat_q <= repeat_d;
      left_q <= left_d;
      blue_q <= blue_d;
      green_q <= green_d;
      done_q <= done_d;
      finished_q <= finished_d;
    end
  end

  `TRLE_ASSERT(a_run_nonzero, clk_i, rst_ni,
    res_valid_o |-> (res_o.run_length != '0), "empty run")
  `TRLE_ASSERT(a_quiet_after_end, clk_i, rst_ni,
    finished_q |-> !res_valid_o, "run after image end")
  `TRLE_ASSERT(a_overrun_ends, clk_i, rst_ni,
    (res_valid_o && res_o.overrun) |-> res_o.image_done, "overrun without image end")
  `TRLE_ASSERT_NEXT(a_done_sets_finished, clk_i, rst_ni,
    res_valid_o && res_o.image_done, finished_q, "finish flag not set")

endmodule
